[hw/rtl/lmm_pkg.sv]
// Shared types, codes and helper functions for the line mirror core.
// No dependencies; used by lmm_ctrl and line_mirror_multi_format_core.
`default_nettype none

package lmm_pkg;

	localparam int LEN_W = 16;
	localparam int PIX_W = 14;
	localparam int FMT_W = 3;

	typedef enum logic [FMT_W-1:0] {
		FMT_GRAY8   = 3'd0,
		FMT_SIXTEEN = 3'd1,
		FMT_RGB888  = 3'd2,
		FMT_UYVY    = 3'd3,
		FMT_YUYV    = 3'd4
	} fmt_t;

	typedef enum logic {
		REG_PIXEL_FORMAT = 1'b0,
		REG_LINE_PIXELS  = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_DATA  = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic       from_mem;
		logic       last;
		logic       err;
		logic [7:0] data;
	} lmm_result_t;

	function automatic logic fmt_known(input logic [FMT_W-1:0] fmt);
		logic ok;
		ok = 1'b0;
		unique case (fmt)
			FMT_GRAY8, FMT_SIXTEEN, FMT_RGB888, FMT_UYVY, FMT_YUYV: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic [LEN_W-1:0] line_len(input logic [FMT_W-1:0] fmt,
			input logic [PIX_W-1:0] pix);
		logic [LEN_W-1:0] len;
		len = '0;
		unique case (fmt)
			FMT_GRAY8:   len = LEN_W'(pix);
			FMT_SIXTEEN: len = {1'b0, pix, 1'b0};
			FMT_RGB888:  len = {1'b0, pix, 1'b0} + LEN_W'(pix);
			FMT_UYVY, FMT_YUYV: len = {1'b0, pix[PIX_W-1:1], 2'b00};
			default: len = '0;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] group_size(input logic [FMT_W-1:0] fmt);
		logic [2:0] g;
		g = 3'd1;
		unique case (fmt)
			FMT_SIXTEEN: g = 3'd2;
			FMT_RGB888:  g = 3'd3;
			FMT_UYVY, FMT_YUYV: g = 3'd4;
			default: g = 3'd1;
		endcase
		return g;
	endfunction

	function automatic logic [1:0] group_map(input logic [FMT_W-1:0] fmt,
			input logic [1:0] phase);
		logic [1:0] m;
		m = phase;
		unique case (fmt)
			FMT_UYVY: m = (phase == 2'd0) ? 2'd0 : (2'd0 - phase);
			FMT_YUYV: m = (phase == 2'd3) ? 2'd3 : (2'd2 - phase);
			default:  m = phase;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/lmm_ram.sv]
// Dual-bank line memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module lmm_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/lmm_ctrl.sv]
// Configuration registers, fill/read counters and mirrored address generation.
// Depends on lmm_pkg.
`default_nettype none

module lmm_ctrl #(
	parameter int LINE_BYTES = 8192,
	parameter int MEM_AW     = 14
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [lmm_pkg::PIX_W-1:0] cfg_wdata,
	input  wire logic                      acc,
	input  wire logic                      cmd,
	input  wire logic [7:0]                data_in,
	output lmm_pkg::lmm_result_t           res,
	output logic                           ram_we,
	output logic [MEM_AW-1:0]              ram_waddr,
	output logic                           ram_re,
	output logic [MEM_AW-1:0]              ram_raddr
);

	import lmm_pkg::*;

	localparam int CNT_W = $clog2(LINE_BYTES + 1);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	logic [FMT_W-1:0] fmt_q;
	logic [PIX_W-1:0] pix_q;
	logic [CNT_W-1:0] wcnt_q, rcnt_q, base_q;
	logic [1:0]       phase_q;
	logic             fsel_q, rfull_q;

	logic [LEN_W-1:0] len;
	logic [CMP_W-1:0] len_c, rcnt_inc, wcnt_inc;
	logic [2:0]       gsz;
	logic             cfg_ok, emit, last, wr, swap;
	logic [CNT_W-1:0] roff;

	logic [CNT_W-1:0] wcnt_d, rcnt_d, base_d;
	logic [1:0]       phase_d;
	logic             fsel_d, rfull_d;

	function automatic logic [MEM_AW-1:0] bank_addr(input logic bank,
			input logic [CNT_W-1:0] off);
		return MEM_AW'(off) + (bank ? MEM_AW'(LINE_BYTES) : MEM_AW'(0));
	endfunction

	always_comb begin
		len      = line_len(fmt_q, pix_q);
		len_c    = CMP_W'(len);
		gsz      = group_size(fmt_q);
		cfg_ok   = fmt_known(fmt_q) && (len != '0) && (len_c <= CMP_W'(LINE_BYTES));
		rcnt_inc = CMP_W'(rcnt_q) + CMP_W'(1);
		emit     = cfg_ok && rfull_q && (CMP_W'(rcnt_q) < len_c);
		last     = rcnt_inc >= len_c;
		wr       = cfg_ok && (cmd == CMD_DATA) && (CMP_W'(wcnt_q) < len_c);
		wcnt_inc = wr ? CMP_W'(wcnt_q) + CMP_W'(1) : CMP_W'(wcnt_q);
		swap     = cfg_ok && (cmd == CMD_DATA) && (wcnt_inc >= len_c);
		roff     = base_q + CNT_W'(group_map(fmt_q, phase_q));

		rcnt_d  = rcnt_q;
		rfull_d = rfull_q;
		base_d  = base_q;
		phase_d = phase_q;
		wcnt_d  = CNT_W'(wcnt_inc);
		fsel_d  = fsel_q;
		if (emit) begin
			rcnt_d = CNT_W'(rcnt_inc);
			if (last) begin
				rfull_d = 1'b0;
			end
			if ({1'b0, phase_q} == gsz - 3'd1) begin
				phase_d = 2'd0;
				base_d  = base_q - CNT_W'(gsz);
			end else begin
				phase_d = phase_q + 2'd1;
			end
		end else begin
			rfull_d = 1'b0;
		end
		if (swap) begin
			fsel_d  = ~fsel_q;
			wcnt_d  = '0;
			rcnt_d  = '0;
			rfull_d = 1'b1;
			phase_d = 2'd0;
			base_d  = CNT_W'(len_c - CMP_W'(gsz));
		end

		res.valid    = cfg_ok ? emit : (cmd == CMD_DATA);
		res.from_mem = cfg_ok;
		res.last     = cfg_ok && last;
		res.err      = !cfg_ok;
		res.data     = data_in;

		ram_we    = acc && wr;
		ram_waddr = bank_addr(fsel_q, wcnt_q);
		ram_re    = acc && emit;
		ram_raddr = bank_addr(~fsel_q, roff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_GRAY8;
			pix_q   <= PIX_W'(640);
			wcnt_q  <= '0;
			rcnt_q  <= '0;
			rfull_q <= 1'b0;
			fsel_q  <= 1'b0;
			base_q  <= '0;
			phase_q <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT: fmt_q <= cfg_wdata[FMT_W-1:0];
				REG_LINE_PIXELS:  pix_q <= cfg_wdata;
				default: ;
			endcase
			wcnt_q  <= '0;
			rcnt_q  <= '0;
			rfull_q <= 1'b0;
		end else if (acc && cfg_ok) begin
			wcnt_q  <= wcnt_d;
			rcnt_q  <= rcnt_d;
			rfull_q <= rfull_d;
			fsel_q  <= fsel_d;
			base_q  <= base_d;
			phase_q <= phase_d;
		end
	end

	a_rfull_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		rfull_q |-> (CMP_W'(rcnt_q) < len_c))
		else $error("held line read past its length");

	a_fill_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(CMP_W'(wcnt_q) < len_c) || (wcnt_q == '0))
		else $error("fill count beyond line length");

	a_one_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && swap && !cfg_we) |=> (fsel_q != $past(fsel_q)) && rfull_q)
		else $error("bank swap not taken");

endmodule

`default_nettype wire

[hw/rtl/line_mirror_multi_format_core.sv]
// Horizontal line mirror for a raw image byte stream in five pixel formats.
// Takes one item per clock while the output is not stalled and, once a line
// is complete, returns its bytes mirrored with pixel byte order kept, lagging
// the input by one line; drain items flush the held line. Each item passes the
// line memory read and then the output register. The rate is one item per
// clock when the output is not stalled, set by the single read and single
// write port of the dual-bank line memory (2*LINE_BYTES bytes). An unknown
// format, an empty line or a line longer than LINE_BYTES passes data bytes
// through with tuser set. Depends on lmm_pkg, lmm_ctrl and lmm_ram.
`default_nettype none

module line_mirror_multi_format_core #(
	parameter int LINE_BYTES = 8192
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [lmm_pkg::PIX_W-1:0] cfg_wdata,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
	input  wire logic                      s_tuser,   // [0] command
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] out_byte
	output logic                           m_tlast,
	output logic                           m_tuser    // [0] config_error
);

	import lmm_pkg::*;

	localparam int MEM_AW = $clog2(2 * LINE_BYTES);

	lmm_result_t       res;
	logic              acc, adv;
	logic              ram_we, ram_re;
	logic [MEM_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_rdata;

	logic              valid_s1, mem_s1, last_s1, err_s1;
	logic [7:0]        data_s1;
	logic              valid_s2, last_s2, err_s2;
	logic [7:0]        data_s2;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	lmm_ctrl #(
		.LINE_BYTES(LINE_BYTES),
		.MEM_AW    (MEM_AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.acc      (acc),
		.cmd      (s_tuser),
		.data_in  (s_tdata),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr)
	);

	lmm_ram #(
		.DEPTH(2 * LINE_BYTES),
		.AW   (MEM_AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_tdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= acc && res.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_s1  <= res.from_mem;
			last_s1 <= res.last;
			err_s1  <= res.err;
			data_s1 <= res.data;
		end
		if (adv && valid_s1) begin
			last_s2 <= last_s1;
			err_s2  <= err_s1;
			data_s2 <= mem_s1 ? ram_rdata : data_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tlast  = last_s2;
	assign m_tuser  = err_s2;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1 && $stable(data_s1) && $stable(mem_s1))
		else $error("stalled stage one item lost");

	a_no_read_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> acc)
		else $error("memory read without accepted item");

	a_err_not_mem: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && mem_s1) |-> !err_s1 && !(ram_we && !acc))
		else $error("memory item flagged as error");

endmodule

`default_nettype wire
